FILE: hw/rtl/mbb3_pkg.sv
// ----------------------------------------------------------------------------
// mbb3_pkg
// Shared widths, register indexes and types of the 3D mask bounding box unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mbb3_pkg;

    localparam int unsigned PosW    = 12;
    localparam int unsigned DimW    = 13;
    localparam int unsigned PadW    = 12;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 13;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx RegSizeX = 2'd0;
    localparam t_cfg_idx RegSizeY = 2'd1;
    localparam t_cfg_idx RegSizeZ = 2'd2;
    localparam t_cfg_idx RegPad   = 2'd3;

    typedef struct packed {
        logic            voxel_set;
        logic [PosW-1:0] pos_x;
        logic [PosW-1:0] pos_y;
        logic [PosW-1:0] pos_z;
        logic            last_voxel;
    } t_voxel;

    typedef struct packed {
        logic cfg_wr;
        logic step;
        logic hit;
        logic last;
    } t_axis_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/mbb3_voxel_if.sv
// ----------------------------------------------------------------------------
// mbb3_voxel_if
// Voxel channel: valid/ready handshake with mask bit, coordinates and last.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbb3_voxel_if;
    logic                      valid;
    logic                      ready;
    logic                      voxel_set;
    logic [mbb3_pkg::PosW-1:0] pos_x;
    logic [mbb3_pkg::PosW-1:0] pos_y;
    logic [mbb3_pkg::PosW-1:0] pos_z;
    logic                      last_voxel;

    modport source (output valid, voxel_set, pos_x, pos_y, pos_z, last_voxel, input ready);
    modport sink   (input valid, voxel_set, pos_x, pos_y, pos_z, last_voxel, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mbb3_box_if.sv
// ----------------------------------------------------------------------------
// mbb3_box_if
// Box channel: valid/ready handshake with padded start and end per axis.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbb3_box_if;
    logic                      valid;
    logic                      ready;
    logic [mbb3_pkg::DimW-1:0] start_x;
    logic [mbb3_pkg::DimW-1:0] start_y;
    logic [mbb3_pkg::DimW-1:0] start_z;
    logic [mbb3_pkg::DimW-1:0] end_x;
    logic [mbb3_pkg::DimW-1:0] end_y;
    logic [mbb3_pkg::DimW-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mask_bounding_box_3d_unit.sv
// ----------------------------------------------------------------------------
// mask_bounding_box_3d_unit
// Bounding box of a binary 3D mask, padded and clamped to the volume size.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              carries
//  i_vox     in   valid/ready            voxel_set, pos_x/y/z, last_voxel
//  o_box     out  valid/ready            start_x/y/z, end_x/y/z
//  i_cfg_*   in   write enable, no wait  size_x/y/z, padding
//
//  One item per cycle unless stalled; an accepted item waits in the input
//  register, and a last item's box goes to the output register when it leaves.
//  Only an item marked last stalls, and only while the output register still
//  holds an untaken box. Reset is synchronous, active low; it sets each size
//  to MAX_DIM, padding to zero and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mask_bounding_box_3d_unit #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mbb3_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [mbb3_pkg::CfgW-1:0]     i_cfg_data,
    mbb3_voxel_if.sink                         i_vox,
    mbb3_box_if.source                         o_box
);

    localparam int unsigned DimW = mbb3_pkg::DimW;

    logic                        r_vox_valid;
    mbb3_pkg::t_voxel            r_vox;
    logic [mbb3_pkg::PadW-1:0]   r_pad;
    logic                        r_out_valid;
    logic [DimW-1:0]             r_start_x, r_start_y, r_start_z;
    logic [DimW-1:0]             r_end_x, r_end_y, r_end_z;

    logic                        out_free, adv, hit;
    logic                        rng_x, rng_y, rng_z;
    logic [DimW-1:0]             st_x, st_y, st_z, en_x, en_y, en_z;
    mbb3_pkg::t_axis_ctrl        ctrl_x, ctrl_y, ctrl_z;

    assign out_free    = !r_out_valid || o_box.ready;
    assign adv         = r_vox_valid && (!r_vox.last_voxel || out_free);
    assign i_vox.ready = !r_vox_valid || adv;
    assign hit         = r_vox.voxel_set && rng_x && rng_y && rng_z;

    always_comb begin
        ctrl_x = '{cfg_wr: i_cfg_we && (i_cfg_idx == mbb3_pkg::RegSizeX),
                   step: adv, hit: hit, last: r_vox.last_voxel};
        ctrl_y = '{cfg_wr: i_cfg_we && (i_cfg_idx == mbb3_pkg::RegSizeY),
                   step: adv, hit: hit, last: r_vox.last_voxel};
        ctrl_z = '{cfg_wr: i_cfg_we && (i_cfg_idx == mbb3_pkg::RegSizeZ),
                   step: adv, hit: hit, last: r_vox.last_voxel};
    end

    mbb3_axis #(.MAX_DIM(MAX_DIM)) u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl_x), .i_cfg_data(i_cfg_data),
        .i_pos(r_vox.pos_x), .i_pad(r_pad), .o_in_range(rng_x),
        .o_start(st_x), .o_end(en_x)
    );

    mbb3_axis #(.MAX_DIM(MAX_DIM)) u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl_y), .i_cfg_data(i_cfg_data),
        .i_pos(r_vox.pos_y), .i_pad(r_pad), .o_in_range(rng_y),
        .o_start(st_y), .o_end(en_y)
    );

    mbb3_axis #(.MAX_DIM(MAX_DIM)) u_axis_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl_z), .i_cfg_data(i_cfg_data),
        .i_pos(r_vox.pos_z), .i_pad(r_pad), .o_in_range(rng_z),
        .o_start(st_z), .o_end(en_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vox_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pad       <= '0;
        end else begin
            if (i_vox.valid && i_vox.ready) begin
                r_vox_valid <= 1'b1;
            end else if (adv) begin
                r_vox_valid <= 1'b0;
            end

            if (adv && r_vox.last_voxel) begin
                r_out_valid <= 1'b1;
            end else if (o_box.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we && (i_cfg_idx == mbb3_pkg::RegPad)) begin
                r_pad <= i_cfg_data[mbb3_pkg::PadW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vox.valid && i_vox.ready) begin
            r_vox <= '{voxel_set: i_vox.voxel_set, pos_x: i_vox.pos_x,
                       pos_y: i_vox.pos_y, pos_z: i_vox.pos_z,
                       last_voxel: i_vox.last_voxel};
        end
        if (adv && r_vox.last_voxel) begin
            r_start_x <= st_x;
            r_start_y <= st_y;
            r_start_z <= st_z;
            r_end_x   <= en_x;
            r_end_y   <= en_y;
            r_end_z   <= en_z;
        end
    end

    assign o_box.valid   = r_out_valid;
    assign o_box.start_x = r_start_x;
    assign o_box.start_y = r_start_y;
    assign o_box.start_z = r_start_z;
    assign o_box.end_x   = r_end_x;
    assign o_box.end_y   = r_end_y;
    assign o_box.end_z   = r_end_z;

endmodule

`default_nettype wire

FILE: hw/rtl/mbb3_axis.sv
// ----------------------------------------------------------------------------
// mbb3_axis
// One axis: size register, running low/high, range check and padded result.
// ----------------------------------------------------------------------------
`default_nettype none

module mbb3_axis #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mbb3_pkg::t_axis_ctrl        i_ctrl,
    input  wire logic [mbb3_pkg::CfgW-1:0]   i_cfg_data,
    input  wire logic [mbb3_pkg::PosW-1:0]   i_pos,
    input  wire logic [mbb3_pkg::PadW-1:0]   i_pad,
    output logic                             o_in_range,
    output logic [mbb3_pkg::DimW-1:0]        o_start,
    output logic [mbb3_pkg::DimW-1:0]        o_end
);

    localparam int unsigned DimW     = mbb3_pkg::DimW;
    localparam int unsigned DimSpan  = 1 << DimW;
    localparam logic [DimW-1:0] ResetSize = DimW'(MAX_DIM % DimSpan);
    localparam logic [DimW-1:0] SizeCap   =
        DimW'((MAX_DIM < DimSpan) ? MAX_DIM : DimSpan - 1);

    logic [DimW-1:0] r_size, n_size;
    logic [DimW-1:0] r_low,  n_low;
    logic [DimW-1:0] r_high, n_high;
    logic [DimW-1:0] upd_low, upd_high, pos_ext, pos_inc;
    logic [DimW:0]   low_diff, end_sum;

    assign pos_ext    = {1'b0, i_pos};
    assign pos_inc    = pos_ext + DimW'(1);
    assign o_in_range = pos_ext < r_size;

    always_comb begin
        upd_low  = r_low;
        upd_high = r_high;
        if (i_ctrl.hit) begin
            if (pos_ext < r_low) begin
                upd_low = pos_ext;
            end
            if (pos_inc > r_high) begin
                upd_high = pos_inc;
            end
        end

        low_diff = {1'b0, upd_low} - {2'b00, i_pad};
        end_sum  = {1'b0, upd_high} + {2'b00, i_pad};
        o_start  = low_diff[DimW] ? '0 : low_diff[DimW-1:0];
        o_end    = (end_sum > {1'b0, r_size}) ? r_size : end_sum[DimW-1:0];

        n_size = r_size;
        n_low  = r_low;
        n_high = r_high;
        if (i_ctrl.cfg_wr) begin
            n_size = (i_cfg_data > SizeCap) ? SizeCap : i_cfg_data;
            n_low  = n_size;
            n_high = '0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.last) begin
                n_low  = r_size;
                n_high = '0;
            end else begin
                n_low  = upd_low;
                n_high = upd_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= ResetSize;
            r_low  <= ResetSize;
            r_high <= '0;
        end else begin
            r_size <= n_size;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mbb3_checker.sv
// ----------------------------------------------------------------------------
// mbb3_checker
// Port-level checks of the bounding box unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbb3_checker #(
    parameter int unsigned MAX_DIM = 4096
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_in_last,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [mbb3_pkg::DimW-1:0] i_start_x,
    input wire logic [mbb3_pkg::DimW-1:0] i_end_x,
    input wire logic [mbb3_pkg::DimW-1:0] i_start_z,
    input wire logic [mbb3_pkg::DimW-1:0] i_end_z
);

    localparam int unsigned DimW    = mbb3_pkg::DimW;
    localparam int unsigned DimSpan = 1 << DimW;
    localparam logic [DimW-1:0] DimLimit =
        DimW'((MAX_DIM < DimSpan) ? MAX_DIM : DimSpan - 1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("box item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_start_x) && $stable(i_end_x)
                                        && $stable(i_start_z) && $stable(i_end_z))
        else $error("box item changed while stalled");

    a_box_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last, 2))
        else $error("box item without a last voxel two cycles before");

    a_box_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_start_x <= DimLimit) && (i_end_x <= DimLimit)
                        && (i_start_z <= DimLimit) && (i_end_z <= DimLimit))
        else $error("box coordinate beyond volume limit");

endmodule

bind mask_bounding_box_3d_unit mbb3_checker #(.MAX_DIM(MAX_DIM)) u_mbb3_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_vox.valid),
    .i_in_ready (i_vox.ready),
    .i_in_last  (i_vox.last_voxel),
    .i_out_valid(o_box.valid),
    .i_out_ready(o_box.ready),
    .i_start_x  (o_box.start_x),
    .i_end_x    (o_box.end_x),
    .i_start_z  (o_box.start_z),
    .i_end_z    (o_box.end_z)
);

`default_nettype wire

FILE: dv/tb_mask_bounding_box_3d_unit.sv
// ----------------------------------------------------------------------------
// tb_mask_bounding_box_3d_unit
// Streams voxel volumes into the bounding box unit with random gaps on both
// channels, predicts each padded, clamped box in the bench and checks every
// box field by field, across several size and padding settings.
// ----------------------------------------------------------------------------
module tb_mask_bounding_box_3d_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxDim = 4096;
    localparam int unsigned DimW = mbb3_pkg::DimW;
    localparam int unsigned PadW = mbb3_pkg::PadW;
    localparam int unsigned PosW = mbb3_pkg::PosW;
    localparam int unsigned CfgW = mbb3_pkg::CfgW;

    typedef struct {
        logic [DimW-1:0] start_at [3];
        logic [DimW-1:0] end_at [3];
    } t_box;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                cfg_we;
    mbb3_pkg::t_cfg_idx  cfg_idx;
    logic [CfgW-1:0]     cfg_data;

    mbb3_voxel_if vox_if ();
    mbb3_box_if   box_if ();

    mask_bounding_box_3d_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vox      (vox_if),
        .o_box      (box_if)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of the volume size, padding and running box
    logic [DimW-1:0] ext [3];
    logic [PadW-1:0] pad;
    logic [DimW-1:0] lo [3];
    logic [DimW-1:0] hi [3];

    mbb3_pkg::t_voxel voxels_to_send [$];
    t_box             boxes_due [$];
    int     vox_pushed = 0;
    int     vox_taken = 0;
    int     n_fail = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    string  axis_name [3] = '{"x", "y", "z"};

    function automatic void restart_axis(int a);
        lo[a] = ext[a];
        hi[a] = '0;
    endfunction

    function automatic void note_reg_write(mbb3_pkg::t_cfg_idx idx, logic [CfgW-1:0] data);
        logic [DimW-1:0] sat;
        sat = (data > MaxDim) ? DimW'(MaxDim) : data;
        case (idx)
            mbb3_pkg::RegSizeX: begin ext[0] = sat; restart_axis(0); end
            mbb3_pkg::RegSizeY: begin ext[1] = sat; restart_axis(1); end
            mbb3_pkg::RegSizeZ: begin ext[2] = sat; restart_axis(2); end
            mbb3_pkg::RegPad:   pad = data[PadW-1:0];
            default: ;
        endcase
    endfunction

    function automatic void track_voxel(mbb3_pkg::t_voxel v);
        logic [PosW-1:0] p [3];
        logic            in_vol;
        logic [DimW:0]   raised;
        t_box            b;
        p[0] = v.pos_x;
        p[1] = v.pos_y;
        p[2] = v.pos_z;
        in_vol = v.voxel_set;
        for (int a = 0; a < 3; a++)
            if (DimW'(p[a]) >= ext[a]) in_vol = 1'b0;
        if (in_vol) begin
            for (int a = 0; a < 3; a++) begin
                if (DimW'(p[a]) < lo[a]) lo[a] = DimW'(p[a]);
                if (DimW'(p[a]) + DimW'(1) > hi[a]) hi[a] = DimW'(p[a]) + DimW'(1);
            end
        end
        if (v.last_voxel) begin
            for (int a = 0; a < 3; a++) begin
                b.start_at[a] = (lo[a] > DimW'(pad)) ? lo[a] - DimW'(pad) : '0;
                raised = {1'b0, hi[a]} + (DimW + 1)'(pad);
                b.end_at[a] = (raised > {1'b0, ext[a]}) ? ext[a] : raised[DimW-1:0];
                restart_axis(a);
            end
            boxes_due.push_back(b);
        end
    endfunction

    function automatic void add_voxel(bit s, logic [PosW-1:0] x, logic [PosW-1:0] y,
                                      logic [PosW-1:0] z, bit l);
        voxels_to_send.push_back('{voxel_set: s, pos_x: x, pos_y: y, pos_z: z,
                                   last_voxel: l});
        vox_pushed++;
    endfunction

    function automatic logic [PosW-1:0] pick_pos(logic [DimW-1:0] lim);
        int r = $urandom_range(99);
        int top = (lim > 4095) ? 4095 : int'(lim);
        if (r < 80) return PosW'($urandom_range(0, top));
        if (r < 92) return PosW'($urandom_range(top - (top > 0), top));
        return PosW'($urandom_range(0, 4095));
    endfunction

    // random volumes; mostly in-range coordinates, some empty masks
    task automatic queue_volumes(int n);
        int cnt;
        int len;
        int set_pct;
        cnt = 0;
        while (cnt < n) begin
            len = $urandom_range(1, 30);
            set_pct = ($urandom_range(99) < 8) ? 0 : $urandom_range(20, 90);
            for (int i = 0; i < len; i++)
                add_voxel($urandom_range(99) < set_pct, pick_pos(ext[0]), pick_pos(ext[1]),
                          pick_pos(ext[2]), i == len - 1);
            cnt += len;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (vox_taken != vox_pushed || boxes_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(mbb3_pkg::t_cfg_idx idx, logic [CfgW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        note_reg_write(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [CfgW-1:0] sx, logic [CfgW-1:0] sy,
                            logic [CfgW-1:0] sz, logic [CfgW-1:0] pd);
        write_reg(mbb3_pkg::RegSizeX, sx);
        write_reg(mbb3_pkg::RegSizeY, sy);
        write_reg(mbb3_pkg::RegSizeZ, sz);
        write_reg(mbb3_pkg::RegPad, pd);
        cfg_we <= 1'b0;
    endtask

    // voxel driver
    always @(posedge i_clk) begin
        mbb3_pkg::t_voxel nxt;
        if (!i_rst_n) begin
            vox_if.valid <= 1'b0;
        end else begin
            if (vox_if.valid && vox_if.ready) begin
                track_voxel('{voxel_set: vox_if.voxel_set, pos_x: vox_if.pos_x,
                              pos_y: vox_if.pos_y, pos_z: vox_if.pos_z,
                              last_voxel: vox_if.last_voxel});
                vox_taken++;
            end
            if (!vox_if.valid || vox_if.ready) begin
                if (voxels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = voxels_to_send.pop_front();
                    vox_if.valid      <= 1'b1;
                    vox_if.voxel_set  <= nxt.voxel_set;
                    vox_if.pos_x      <= nxt.pos_x;
                    vox_if.pos_y      <= nxt.pos_y;
                    vox_if.pos_z      <= nxt.pos_z;
                    vox_if.last_voxel <= nxt.last_voxel;
                end else begin
                    vox_if.valid <= 1'b0;
                end
            end
        end
    end

    // box monitor
    always @(posedge i_clk) begin
        t_box got;
        t_box want;
        if (i_rst_n && box_if.valid && box_if.ready) begin
            got.start_at = '{box_if.start_x, box_if.start_y, box_if.start_z};
            got.end_at   = '{box_if.end_x, box_if.end_y, box_if.end_z};
            if (boxes_due.size() == 0) begin
                $error("box with no voxel volume pending");
                n_fail++;
            end else begin
                want = boxes_due.pop_front();
                for (int a = 0; a < 3; a++) begin
                    if (got.start_at[a] !== want.start_at[a]) begin
                        $error("start_%s: expected %0d, got %0d", axis_name[a],
                               want.start_at[a], got.start_at[a]);
                        n_fail++;
                    end
                    if (got.end_at[a] !== want.end_at[a]) begin
                        $error("end_%s: expected %0d, got %0d", axis_name[a],
                               want.end_at[a], got.end_at[a]);
                        n_fail++;
                    end
                end
            end
        end
        if (!i_rst_n) box_if.ready <= 1'b0;
        else          box_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #(2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = mbb3_pkg::RegSizeX;
        cfg_data          = '0;
        vox_if.valid      = 1'b0;
        vox_if.voxel_set  = 1'b0;
        vox_if.pos_x      = '0;
        vox_if.pos_y      = '0;
        vox_if.pos_z      = '0;
        vox_if.last_voxel = 1'b0;
        box_if.ready      = 1'b0;
        ext = '{DimW'(MaxDim), DimW'(MaxDim), DimW'(MaxDim)};
        pad = '0;
        for (int a = 0; a < 3; a++) restart_axis(a);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 53;

        // empty mask, corners, alternating bits, unset last
        add_voxel(0, 0, 0, 0, 1);
        add_voxel(1, 0, 0, 0, 1);
        add_voxel(1, 4095, 4095, 4095, 1);
        add_voxel(1, 4095, 0, 2048, 0);
        add_voxel(1, 0, 4095, 1, 0);
        add_voxel(0, 100, 100, 100, 0);
        add_voxel(1, 12'hAAA, 12'h555, 12'hAAA, 1);
        add_voxel(1, 12'h555, 12'hAAA, 12'h555, 0);
        add_voxel(0, 7, 7, 7, 1);
        // open volume; size write restarts x only
        add_voxel(1, 50, 60, 70, 0);
        add_voxel(1, 3000, 10, 10, 0);
        wait_idle();
        write_reg(mbb3_pkg::RegSizeX, 13'h1FFF);
        write_reg(mbb3_pkg::RegPad, 13'h1001);
        cfg_we <= 1'b0;
        add_voxel(1, 10, 20, 30, 1);
        add_voxel(1, 0, 0, 0, 0);
        add_voxel(1, 4095, 4095, 4095, 1);
        wait_idle();

        set_regs(13'h1FFF, 13'd4096, 13'h1000, 13'h0FFF);
        queue_volumes(150);
        wait_idle();
        set_regs(13'd1, 13'd1, 13'd1, 13'd0);
        queue_volumes(150);
        wait_idle();

        send_idle_pct = 53;
        recv_idle_pct = 17;
        set_regs(13'd5, 13'd7, 13'd3, 13'h1001);
        queue_volumes(150);
        wait_idle();
        set_regs(13'd0, 13'd16, 13'd4096, 13'd2);
        queue_volumes(150);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(CfgW'($urandom_range(1, 64)), CfgW'($urandom_range(1, 64)),
                 CfgW'($urandom_range(1, 64)), CfgW'($urandom_range(0, 8)));
        queue_volumes(150);
        wait_idle();
        set_regs(CfgW'($urandom_range(0, 8191)), CfgW'($urandom_range(0, 8191)),
                 CfgW'($urandom_range(0, 8191)), CfgW'($urandom_range(0, 8191)));
        queue_volumes(150);
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (n_fail == 0 && boxes_due.size() == 0) $display("RESULT: OK");
        else                                      $display("RESULT: ERROR");
        $finish;
    end

endmodule
